// ===== rtl/sll_pkg.sv =====
`default_nettype none

package sll_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam int BREAK_W = 31;
    localparam int LABEL_W = 8;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_DROPPED = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    typedef struct packed {
        logic [BREAK_W-1:0] brk;
        logic [LABEL_W-1:0] left;
        logic [LABEL_W-1:0] right;
    } seg_t;

endpackage

`default_nettype wire

// ===== rtl/segment_label_lookup.sv =====
// Loads (start and append) produce no result; busy stays low.
// A query first reads the segment table at the walk pointer, then compares the
// entries one at a time as the walk pointer passes them, until the walk stops.
// A query on an empty table answers in the next cycle. The result strobe done is
// high for exactly one cycle and the receiver cannot stall it.
// Reset (rst_n low, asynchronous) empties the table and clears pointer and flags.
`default_nettype none

module segment_label_lookup
    import sll_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [BREAK_W-1:0] breakpoint,
    input  wire logic [LABEL_W-1:0] left_label,
    input  wire logic [LABEL_W-1:0] right_label,
    input  wire logic [BREAK_W-1:0] query_index,
    output logic                    done,
    output logic [LABEL_W-1:0]      left_result,
    output logic [LABEL_W-1:0]      right_result,
    output logic [1:0]              status
);

    localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

    seg_t seg_mem [MAX_SEGMENTS];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   seg_count_reg, seg_count_next;
    logic [ADDR_W-1:0]  walk_ptr_reg, walk_ptr_next;
    logic               dropped_reg, dropped_next;
    logic [BREAK_W-1:0] query_reg;
    seg_t               rd_data_reg;
    logic               done_reg, done_next;
    logic [LABEL_W-1:0] left_reg, left_next;
    logic [LABEL_W-1:0] right_reg, right_next;
    logic [1:0]         status_reg, status_next;

    logic               accept;
    logic               is_start, is_append, is_query;
    logic               table_full;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CNT_W-1:0]   ptr_plus;
    logic               can_advance;

    assign accept     = start && (state_reg == ST_IDLE);
    assign is_start   = accept && (opcode == OP_START);
    assign is_append  = accept && (opcode == OP_APPEND);
    assign is_query   = accept && (opcode == OP_QUERY);
    assign table_full = (seg_count_reg == SEG_MAX);
    assign ptr_plus   = CNT_W'(walk_ptr_reg) + CNT_W'(1);

    // The walk moves on while another segment exists and the query is at or past
    // the breakpoint of the segment just read.
    assign can_advance = (ptr_plus < seg_count_reg) && (query_reg >= rd_data_reg.brk);

    assign wr_en   = is_start || (is_append && !table_full);
    assign wr_addr = is_start ? '0 : seg_count_reg[ADDR_W-1:0];
    assign rd_addr = (state_reg == ST_WALK) ? ptr_plus[ADDR_W-1:0] : walk_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[wr_addr] <= '{brk: breakpoint, left: left_label, right: right_label};
        end
        rd_data_reg <= seg_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query && (seg_count_reg != '0))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!can_advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        seg_count_next = seg_count_reg;
        walk_ptr_next  = walk_ptr_reg;
        dropped_next   = dropped_reg;
        done_next      = 1'b0;
        left_next      = left_reg;
        right_next     = right_reg;
        status_next    = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_start)
                begin
                    seg_count_next = CNT_W'(1);
                    walk_ptr_next  = '0;
                    dropped_next   = 1'b0;
                end
                else if (is_append)
                begin
                    if (table_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        seg_count_next = seg_count_reg + CNT_W'(1);
                    end
                end
                else if (is_query && (seg_count_reg == '0))
                begin
                    done_next   = 1'b1;
                    left_next   = '0;
                    right_next  = '0;
                    status_next = STAT_EMPTY;
                end
            end
            ST_WALK:
            begin
                if (can_advance)
                begin
                    walk_ptr_next = ptr_plus[ADDR_W-1:0];
                end
                else
                begin
                    done_next   = 1'b1;
                    left_next   = rd_data_reg.left;
                    right_next  = rd_data_reg.right;
                    status_next = dropped_reg ? STAT_DROPPED : STAT_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_count_reg <= '0;
            walk_ptr_reg  <= '0;
            dropped_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_count_reg <= seg_count_next;
            walk_ptr_reg  <= walk_ptr_next;
            dropped_reg   <= dropped_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            query_reg <= query_index;
        end
        left_reg   <= left_next;
        right_reg  <= right_next;
        status_reg <= status_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign left_result  = left_reg;
    assign right_result = right_reg;
    assign status       = status_reg;

    a_ptr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_count_reg != '0) |-> (CNT_W'(walk_ptr_reg) < seg_count_reg))
        else $error("walk pointer beyond loaded segments");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_count_reg <= SEG_MAX)
        else $error("segment count beyond capacity");

    a_no_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !done_reg)
        else $error("result strobe while a walk is running");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_WALK || is_query))
        else $error("result strobe without a query transaction");

    a_ptr_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |=> (walk_ptr_reg == $past(walk_ptr_reg)
            || walk_ptr_reg == $past(ptr_plus[ADDR_W-1:0])))
        else $error("walk pointer moved other than one step forward");

endmodule

`default_nettype wire
